/* rtl/trcd_pkg.sv */
// Shared types, constants and helper functions for the tape record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package trcd_pkg;

    localparam int WORD_W   = 36;
    localparam int HALF_W   = 18;
    localparam int FORMAT_W = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    // Header word positions inside a record
    localparam int HDR_SAVESET_POS = 2;
    localparam int HDR_FILE_POS    = 3;
    localparam int HDR_TYPE_POS    = 4;
    localparam int HDR_SEQ_POS     = 5;

    localparam logic [FORMAT_W-1:0] FORMAT_RESET   = 3'd4;
    localparam logic [FORMAT_W-1:0] FORMAT_EAC_MAX = 3'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_MARK,
        OP_END
    } op_t;

    typedef struct packed {
        op_t   op;
        word_t word;
    } cmd_t;

    typedef struct packed {
        logic record_open;
        logic out_full;
    } bk_status_t;

    typedef struct packed {
        word_t       record_sum;
        word_t       seal_word;
        logic [2:0]  type_code;
        logic        type_known;
        half_t       saveset_num;
        half_t       tape_num;
        half_t       file_num;
        half_t       page_num;
        word_t       record_seq;
        logic        complete;
    } result_t;

    // One checksum step: end-around-carry add, or rotate left by one then add
    function automatic word_t fold_word(input word_t acc, input word_t w, input logic rot);
        word_t             r;
        logic [WORD_W:0]   s;
        begin
            r = rot ? {acc[WORD_W-2:0], acc[WORD_W-1]} : acc;
            s = {1'b0, r} + {1'b0, w};
            if (!rot && s[WORD_W])
            begin
                s = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, 1'b1};
            end
            fold_word = s[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/trcd_front.sv */
// Front end of the deframer: accepts tape words and classifies them into commands.
// Depends on trcd_pkg; feeds trcd_queue.
`default_nettype none

module trcd_front
    import trcd_pkg::*;
(
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire word_t tape_word,
    input  wire logic  record_start,
    input  wire logic  tape_end,
    input  wire logic  q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // End of tape wins over a start mark
    always_comb
    begin
        push_cmd.word = tape_word;
        if (tape_end)
        begin
            push_cmd.op = OP_END;
        end
        else if (record_start)
        begin
            push_cmd.op = OP_MARK;
        end
        else
        begin
            push_cmd.op = OP_WORD;
        end
    end

endmodule

`default_nettype wire

/* rtl/trcd_queue.sv */
// Two-entry command queue between the front end and the record engine.
// Depends on trcd_pkg.
`default_nettype none

module trcd_queue
    import trcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      q_full,
    output logic      q_valid,
    input  wire logic pop,
    output cmd_t      q_cmd
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/trcd_back.sv */
// Record engine: folds the checksum, captures header words, closes records
// and holds the result register. Depends on trcd_pkg.
`default_nettype none

module trcd_back
    import trcd_pkg::*;
#(
    parameter int RECORD_WORDS = 518
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rotate_mode,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      pop,
    output bk_status_t status,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    localparam int IDX_W = $clog2(RECORD_WORDS + 1);

    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [IDX_W-1:0] index_inc;
    logic             open_reg;
    logic             open_next;
    word_t            sum_reg;
    word_t            sum_next;
    word_t            hdr_st_reg;
    word_t            hdr_st_next;
    word_t            hdr_fp_reg;
    word_t            hdr_fp_next;
    word_t            hdr_type_reg;
    word_t            hdr_type_next;
    word_t            hdr_seq_reg;
    word_t            hdr_seq_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          res_reg;
    result_t          res_next;
    logic             emit;
    logic             emit_full;
    word_t            src_sum;
    word_t            src_st;
    word_t            src_fp;
    word_t            src_type;
    word_t            src_seq;
    word_t            neg_type;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign index_inc = index_reg + 1'b1;

    // State update for one command
    always_comb
    begin
        index_next    = index_reg;
        open_next     = open_reg;
        sum_next      = sum_reg;
        hdr_st_next   = hdr_st_reg;
        hdr_fp_next   = hdr_fp_reg;
        hdr_type_next = hdr_type_reg;
        hdr_seq_next  = hdr_seq_reg;
        emit          = 1'b0;
        emit_full     = 1'b0;
        if (pop)
        begin
            case (q_cmd.op)
                OP_END:
                begin
                    emit       = open_reg;
                    open_next  = 1'b0;
                    index_next = '0;
                end
                OP_WORD, OP_MARK:
                begin
                    if (!open_reg || q_cmd.op == OP_MARK)
                    begin
                        // Close any open record short, then open a new one
                        emit          = open_reg;
                        open_next     = 1'b1;
                        index_next    = IDX_W'(1);
                        sum_next      = q_cmd.word;
                        hdr_st_next   = '0;
                        hdr_fp_next   = '0;
                        hdr_type_next = '0;
                        hdr_seq_next  = '0;
                    end
                    else
                    begin
                        sum_next = fold_word(sum_reg, q_cmd.word, rotate_mode);
                        if (index_reg == IDX_W'(HDR_SAVESET_POS))
                        begin
                            hdr_st_next = q_cmd.word;
                        end
                        if (index_reg == IDX_W'(HDR_FILE_POS))
                        begin
                            hdr_fp_next = q_cmd.word;
                        end
                        if (index_reg == IDX_W'(HDR_TYPE_POS))
                        begin
                            hdr_type_next = q_cmd.word;
                        end
                        if (index_reg == IDX_W'(HDR_SEQ_POS))
                        begin
                            hdr_seq_next = q_cmd.word;
                        end
                        if (index_inc == IDX_W'(RECORD_WORDS))
                        begin
                            emit       = 1'b1;
                            emit_full  = 1'b1;
                            open_next  = 1'b0;
                            index_next = '0;
                        end
                        else
                        begin
                            index_next = index_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result assembly: a full record reports the updated state, a cut one the old
    always_comb
    begin
        src_sum  = emit_full ? sum_next      : sum_reg;
        src_st   = emit_full ? hdr_st_next   : hdr_st_reg;
        src_fp   = emit_full ? hdr_fp_next   : hdr_fp_reg;
        src_type = emit_full ? hdr_type_next : hdr_type_reg;
        src_seq  = emit_full ? hdr_seq_next  : hdr_seq_reg;
        neg_type = ~src_type + 1'b1;

        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            res_next.record_sum  = src_sum;
            res_next.seal_word   = ~src_sum;
            res_next.type_known  = (neg_type[WORD_W-1:3] == '0);
            res_next.type_code   = (neg_type[WORD_W-1:3] == '0) ? neg_type[2:0] : 3'd0;
            res_next.saveset_num = src_st[WORD_W-1:HALF_W];
            res_next.tape_num    = src_st[HALF_W-1:0];
            res_next.file_num    = src_fp[WORD_W-1:HALF_W];
            res_next.page_num    = src_fp[HALF_W-1:0];
            res_next.record_seq  = src_seq;
            res_next.complete    = emit_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            open_reg      <= 1'b0;
            sum_reg       <= '0;
            hdr_st_reg    <= '0;
            hdr_fp_reg    <= '0;
            hdr_type_reg  <= '0;
            hdr_seq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg     <= index_next;
            open_reg      <= open_next;
            sum_reg       <= sum_next;
            hdr_st_reg    <= hdr_st_next;
            hdr_fp_reg    <= hdr_fp_next;
            hdr_type_reg  <= hdr_type_next;
            hdr_seq_reg   <= hdr_seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid          = out_valid_reg;
    assign result             = res_reg;
    assign status.record_open = open_reg;
    assign status.out_full    = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/tape_record_checksum_deframer.sv */
// Top level of the tape record deframer with 36-bit record checksum.
// Depends on trcd_pkg, trcd_front, trcd_queue and trcd_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tape word per transaction with
//   its start mark and end-of-tape flag. Output channel (out_valid/out_ready)
//   carries one transaction per closed record: checksum, seal word, decoded
//   header fields and the complete flag. The configuration channel
//   (cfg_valid/cfg_ready/cfg_data) writes format_level; cfg_ready is always high.
//   Write it only while no record result is outstanding.
// Timing:
//   One word per cycle sustained while out_ready keeps up; the checksum fold (one
//   36-bit add with end-around carry, or rotate and add) in the record engine
//   sets that figure. out_valid is registered, behind the queue and the engine.
// Reset:
//   Clears the queue, closes any record, zeroes the checksum and header
//   registers and sets format_level to 4.
// Stalls:
//   While a result waits for out_ready the engine holds; the two-entry queue
//   absorbs further words and in_ready drops once it is full.
`default_nettype none

module tape_record_checksum_deframer
    import trcd_pkg::*;
#(
    parameter int RECORD_WORDS = 518
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [FORMAT_W-1:0] cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire word_t               tape_word,
    input  wire logic                record_start,
    input  wire logic                tape_end,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output word_t                    record_sum,
    output word_t                    seal_word,
    output logic [2:0]               type_code,
    output logic                     type_known,
    output half_t                    saveset_num,
    output half_t                    tape_num,
    output half_t                    file_num,
    output half_t                    page_num,
    output word_t                    record_seq,
    output logic                     complete
);

    logic [FORMAT_W-1:0] format_reg;
    logic [FORMAT_W-1:0] format_next;
    logic                push;
    cmd_t                push_cmd;
    logic                q_full;
    logic                q_valid;
    logic                pop;
    cmd_t                q_cmd;
    bk_status_t          bk_status;
    result_t             result;

    // Configuration: take every write at once
    assign cfg_ready   = 1'b1;
    assign format_next = cfg_valid ? cfg_data : format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FORMAT_RESET;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // Classify incoming words into commands
    trcd_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tape_word    (tape_word),
        .record_start (record_start),
        .tape_end     (tape_end),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // Decouple the front end from the record engine
    trcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .q_cmd    (q_cmd)
    );

    // Fold, capture headers and close records; rotate-add above format 4
    trcd_back #(
        .RECORD_WORDS (RECORD_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rotate_mode (format_reg > FORMAT_EAC_MAX),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .status      (bk_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign record_sum  = result.record_sum;
    assign seal_word   = result.seal_word;
    assign type_code   = result.type_code;
    assign type_known  = result.type_known;
    assign saveset_num = result.saveset_num;
    assign tape_num    = result.tape_num;
    assign file_num    = result.file_num;
    assign page_num    = result.page_num;
    assign record_seq  = result.record_seq;
    assign complete    = result.complete;

`ifndef SYNTHESIS
    // End of tape always leaves no record open
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_cmd.op == OP_END) |=> !bk_status.record_open)
        else $error("record still open after end of tape");

    // A new result only follows a command taken by the engine
    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop))
        else $error("result raised without a command");

    // An unknown type always reports code zero
    a_unknown_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !type_known) |-> (type_code == 3'd0))
        else $error("unknown type carries a nonzero code");
`endif

endmodule

`default_nettype wire

/* tb/sv/tape_record_checksum_deframer_tb.sv */
// Self-checking testbench for tape_record_checksum_deframer: record framing,
// checksum folds, header decode and handshake stalls. Depends on trcd_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tape_record_checksum_deframer_tb;
    import trcd_pkg::*;

    localparam int REC_WORDS    = 518;
    localparam int DRAIN_CYCLES = 16;    // queue depth plus pipeline, with margin
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off under pressure

    // ------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [FORMAT_W-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    word_t               tape_word;
    logic                record_start;
    logic                tape_end;
    logic                out_valid;
    logic                out_ready = 1'b0;
    word_t               record_sum;
    word_t               seal_word;
    logic [2:0]          type_code;
    logic                type_known;
    half_t               saveset_num;
    half_t               tape_num;
    half_t               file_num;
    half_t               page_num;
    word_t               record_seq;
    logic                complete;

    always #5 clk = ~clk;

    tape_record_checksum_deframer #(
        .RECORD_WORDS (REC_WORDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tape_word    (tape_word),
        .record_start (record_start),
        .tape_end     (tape_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .record_sum   (record_sum),
        .seal_word    (seal_word),
        .type_code    (type_code),
        .type_known   (type_known),
        .saveset_num  (saveset_num),
        .tape_num     (tape_num),
        .file_num     (file_num),
        .page_num     (page_num),
        .record_seq   (record_seq),
        .complete     (complete)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the deframer's registers
    // ------------------------------------------------------------------
    logic [FORMAT_W-1:0] format_level;
    int                  words_in_record;
    logic                record_is_open;
    word_t               sum_acc;
    word_t               saveset_tape_hdr;
    word_t               file_page_hdr;
    word_t               type_word_hdr;
    word_t               sequence_hdr;

    result_t pending_records[$];   // closed records whose result is still due
    int      mismatches = 0;

    // Idling controls; the receiver percentage is read by its own process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Hold-off request: bump the token, the receiver process counts the cycles
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One checksum step: end-around-carry add at low formats, rotate-add above
    function automatic word_t fold_checksum(input word_t acc, input word_t w);
        logic [WORD_W:0] total;
        if (format_level <= FORMAT_EAC_MAX)
        begin
            total = {1'b0, acc} + {1'b0, w};
            if (total[WORD_W])
            begin
                total = total + 1'b1;
            end
        end
        else
        begin
            total = {1'b0, acc[WORD_W-2:0], acc[WORD_W-1]} + {1'b0, w};
        end
        return total[WORD_W-1:0];
    endfunction

    // Close the open record and queue the result it should produce
    task automatic close_record(input logic full);
        result_t rec;
        word_t   type_val;
        type_val        = word_t'(0) - type_word_hdr;
        rec.record_sum  = sum_acc;
        rec.seal_word   = ~sum_acc;
        rec.type_known  = (type_val <= word_t'(7));
        rec.type_code   = rec.type_known ? type_val[2:0] : 3'd0;
        rec.saveset_num = saveset_tape_hdr[WORD_W-1:HALF_W];
        rec.tape_num    = saveset_tape_hdr[HALF_W-1:0];
        rec.file_num    = file_page_hdr[WORD_W-1:HALF_W];
        rec.page_num    = file_page_hdr[HALF_W-1:0];
        rec.record_seq  = sequence_hdr;
        rec.complete    = full;
        pending_records.push_back(rec);
        record_is_open  = 1'b0;
        words_in_record = 0;
    endtask

    // Fold one word into the open record and capture it at a header position
    task automatic absorb_word(input word_t w);
        sum_acc = fold_checksum(sum_acc, w);
        case (words_in_record)
            HDR_SAVESET_POS: saveset_tape_hdr = w;
            HDR_FILE_POS:    file_page_hdr    = w;
            HDR_TYPE_POS:    type_word_hdr    = w;
            HDR_SEQ_POS:     sequence_hdr     = w;
            default: ;
        endcase
        words_in_record++;
    endtask

    // Apply one accepted input transaction to the predictor
    task automatic predict_word(input word_t w, input logic mark, input logic eot);
        if (eot)
        begin
            // End of tape wins over any mark; the word itself is dropped
            if (record_is_open)
            begin
                close_record(1'b0);
            end
            words_in_record = 0;
        end
        else
        begin
            if (record_is_open && mark)
            begin
                close_record(1'b0);
            end
            if (!record_is_open)
            begin
                record_is_open   = 1'b1;
                words_in_record  = 0;
                sum_acc          = '0;
                saveset_tape_hdr = '0;
                file_page_hdr    = '0;
                type_word_hdr    = '0;
                sequence_hdr     = '0;
            end
            absorb_word(w);
            if (words_in_record >= REC_WORDS)
            begin
                close_record(1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off when requested
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each output transaction with the oldest record
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_records.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected record result, expected none actual sum %h",
                         $time, record_sum);
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("record_sum",  want.record_sum,  record_sum);
                check_field("seal_word",   want.seal_word,   seal_word);
                check_field("type_code",   want.type_code,   type_code);
                check_field("type_known",  want.type_known,  type_known);
                check_field("saveset_num", want.saveset_num, saveset_num);
                check_field("tape_num",    want.tape_num,    tape_num);
                check_field("file_num",    want.file_num,    file_num);
                check_field("page_num",    want.page_num,    page_num);
                check_field("record_seq",  want.record_seq,  record_seq);
                check_field("complete",    want.complete,    complete);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random word, biased now and then towards all zeros and all ones
    function automatic word_t rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return word_t'({$urandom, $urandom});
        endcase
    endfunction

    // Plausible content for a given position; the type word is mostly a negated type
    function automatic word_t record_word(input int pos);
        if (pos == HDR_TYPE_POS && $urandom_range(6) != 0)
        begin
            return word_t'(0) - word_t'($urandom_range(7));
        end
        return rand_word();
    endfunction

    // Offer one input transaction, hold it until accepted, then predict it
    task automatic send_item(input word_t w, input logic mark, input logic eot);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        tape_word    <= w;
        record_start <= mark;
        tape_end     <= eot;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_word(w, mark, eot);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write format_level while the block is idle
    task automatic write_format(input logic [FORMAT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid    <= 1'b0;
        format_level = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Records of random length with noise: stray marks, stray end-of-tape items
    task automatic run_record_stream(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(11) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if (i != 0 && $urandom_range(39) == 0)
                begin
                    send_item(rand_word(), 1'($urandom_range(1)), 1'b1);
                    sent++;
                end
                send_item(record_word(i),
                          (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0),
                          1'b0);
                sent++;
            end
            // Close with end of tape now and then; otherwise the next mark cuts it
            if ($urandom_range(2) == 0)
            begin
                send_item(rand_word(), 1'($urandom_range(1)), 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked cases at the reset format, then a few rotate-add words
    task automatic test_directed();
        set_idling(0, 0);
        // End of tape with nothing open, alone and with a mark: no result
        send_item('1, 1'b0, 1'b1);
        send_item('0, 1'b1, 1'b1);
        // Record with an all-ones saveset/tape header and type 7, cut by end of tape before word 5
        send_item('1, 1'b1, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item('1, 1'b0, 1'b0);
        send_item(36'h000000001, 1'b0, 1'b0);
        send_item(word_t'(0) - word_t'(7), 1'b0, 1'b0);
        send_item(36'h123456789, 1'b0, 1'b1);
        // Unmarked word opens a record; all-ones pair forces the end-around carry
        send_item('1, 1'b0, 1'b0);
        send_item('1, 1'b0, 1'b0);
        // Marked word cuts it short with no header seen, and starts the next record
        send_item(36'h800000000, 1'b1, 1'b0);
        send_item(36'h7ffffffff, 1'b0, 1'b0);
        send_item(36'h0003ffff0, 1'b0, 1'b0);
        send_item(36'hfffc0000f, 1'b0, 1'b0);
        send_item(word_t'(0) - word_t'(8), 1'b0, 1'b0);   // just past the last type
        send_item('1, 1'b0, 1'b0);
        // End of tape with a mark while open: close only, open nothing
        send_item('0, 1'b1, 1'b1);
        // Type word 1 decodes far out of range; type word 0 is plain data
        send_item('0, 1'b1, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item(36'h000000001, 1'b0, 1'b0);
        send_item(36'h000000000, 1'b1, 1'b0);
        send_item('0, 1'b0, 1'b1);
        // Rotate-add: the top bit must wrap into bit 0
        write_format(3'd7);
        send_item('1, 1'b1, 1'b0);
        send_item(36'h800000000, 1'b0, 1'b0);
        send_item('1, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b1);
    endtask

    // A record that runs to full length, then a mark with nothing open
    task automatic test_full_record();
        write_format(3'd0);
        set_idling(0, 0);
        for (int i = 0; i < REC_WORDS; i++)
        begin
            send_item(record_word(i), (i == 0), 1'b0);
        end
        send_item(rand_word(), 1'b1, 1'b0);
        send_item(rand_word(), 1'b0, 1'b0);
        send_item(rand_word(), 1'b0, 1'b1);
    endtask

    // One random phase at a given format and idling mix
    task automatic test_random_phase(input logic [FORMAT_W-1:0] fmt, input int send_pct,
                                     input int recv_pct, input int n_items);
        write_format(fmt);
        set_idling(send_pct, recv_pct);
        run_record_stream(n_items);
    endtask

    // Hold the receiver off while short records keep coming, so the queue fills
    task automatic test_backpressure();
        write_format(3'd1);
        set_idling(0, 0);
        hold_token <= hold_token + 1;
        for (int i = 0; i < 60; i++)
        begin
            send_item(rand_word(), ($urandom_range(2) == 0), 1'b0);
        end
        send_item(rand_word(), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        tape_word    <= '0;
        record_start <= 1'b0;
        tape_end     <= 1'b0;

        format_level     = FORMAT_RESET;
        words_in_record  = 0;
        record_is_open   = 1'b0;
        sum_acc          = '0;
        saveset_tape_hdr = '0;
        file_page_hdr    = '0;
        type_word_hdr    = '0;
        sequence_hdr     = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_record();
        test_random_phase(3'd5, 0, 0, 100);
        test_random_phase(3'd6, 58, 0, 100);
        test_random_phase(3'd3, 0, 58, 100);
        test_random_phase(3'd7, 32, 32, 100);
        test_backpressure();
        test_random_phase(3'd4, 0, 0, 40);

        wait_drained();
        if (mismatches == 0 && pending_records.size() == 0)
        begin
            $display("tape_record_checksum_deframer_tb: clean");
        end
        else
        begin
            $display("tape_record_checksum_deframer_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tape_record_checksum_deframer_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
